FILE: src/cc20_pkg.sv
// Package: shared widths, register indexes, round function and control/status types for ChaCha20.
package cc20_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int STATE_WORDS = 16;
    localparam int KEY_WORDS   = 8;
    localparam int POS_W       = 4;

    typedef logic [WORD_W-1:0] word_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0_TO_7     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_8_TO_15    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_16_TO_23   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_24_TO_31   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNTER  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_0_TO_7   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_8_TO_11  = 3'd6;

    // The "expand 32-byte k" constant words.
    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646E;
    localparam word_t SIGMA_2 = 32'h7962_2D32;
    localparam word_t SIGMA_3 = 32'h6B20_6574;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_init;
        logic round_en;
        logic diag;
        logic final_add;
        logic out_load;
        logic out_from_hold;
    } cc20_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_zero;
    } cc20_status_t;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic quad_t quarter_round(quad_t q);
        quad_t r;
        r = q;
        r.a = r.a + r.b;
        r.d = rotl(r.d ^ r.a, 16);
        r.c = r.c + r.d;
        r.b = rotl(r.b ^ r.c, 12);
        r.a = r.a + r.b;
        r.d = rotl(r.d ^ r.a, 8);
        r.c = r.c + r.d;
        r.b = rotl(r.b ^ r.c, 7);
        return r;
    endfunction

endpackage

FILE: src/cc20_msg_if.sv
// Interface: message channel carrying one plaintext word per beat.
interface cc20_msg_if
    import cc20_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   message_word;
    logic [COUNT_W-1:0]  byte_count;
    logic                end_of_message;

    modport source (output valid, output message_word, output byte_count,
                    output end_of_message, input ready);
    modport sink   (input valid, input message_word, input byte_count,
                    input end_of_message, output ready);
endinterface

FILE: src/cc20_res_if.sv
// Interface: result channel carrying one cipher word per beat.
interface cc20_res_if
    import cc20_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   cipher_word;
    logic [COUNT_W-1:0]  valid_bytes;
    logic                final_word;

    modport source (output valid, output cipher_word, output valid_bytes,
                    output final_word, input ready);
    modport sink   (input valid, input cipher_word, input valid_bytes,
                    input final_word, output ready);
endinterface

FILE: src/cc20_datapath.sv
// Datapath: key/nonce/counter registers, round state, keystream XOR and result register.
module cc20_datapath
    import cc20_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [WORD_W-1:0]      message_word,
    input  logic [COUNT_W-1:0]     byte_count,
    input  logic                   end_of_message,
    input  cc20_cmd_t              cmd,
    output cc20_status_t           status,
    output logic [WORD_W-1:0]      cipher_word,
    output logic [COUNT_W-1:0]     valid_bytes,
    output logic                   final_word
);

    word_t               key_reg [KEY_WORDS];
    word_t               ctr_reg, ctr_next;
    word_t               nonce0_reg, nonce0_next;
    word_t               nonce1_reg;
    word_t               nonce2_reg;
    word_t               state_reg [STATE_WORDS];
    word_t               init_w [STATE_WORDS];
    word_t               rnd_next [STATE_WORDS];
    logic [POS_W-1:0]    pos_reg, pos_next;
    word_t               hold_word_reg;
    logic [COUNT_W-1:0]  hold_count_reg;
    logic                hold_last_reg;
    word_t               cipher_word_reg;
    logic [COUNT_W-1:0]  valid_bytes_reg;
    logic                final_word_reg;
    word_t               lo_half, hi_half;

    assign lo_half = cfg_data[WORD_W-1:0];
    assign hi_half = cfg_data[CFG_DATA_W-1:WORD_W];

    // Block input words built from the constant, key, counter and nonce.
    always_comb
    begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        for (int k = 0; k < KEY_WORDS; k++)
        begin
            init_w[4 + k] = key_reg[k];
        end
        init_w[12] = ctr_reg;
        init_w[13] = nonce0_reg;
        init_w[14] = nonce1_reg;
        init_w[15] = nonce2_reg;
    end

    // One column or diagonal round: four quarter rounds side by side.
    always_comb
    begin
        logic [1:0] lane;
        logic [1:0] off;
        logic [3:0] ia, ib, ic, id;
        quad_t      q;
        for (int w = 0; w < STATE_WORDS; w++)
        begin
            rnd_next[w] = state_reg[w];
        end
        for (int l = 0; l < 4; l++)
        begin
            lane = 2'(l);
            off  = {1'b0, cmd.diag};
            ia   = {2'b00, lane};
            ib   = {2'b01, lane + off};
            ic   = {2'b10, lane + (off << 1)};
            id   = {2'b11, lane + (off << 1) + off};
            q    = quarter_round('{state_reg[ia], state_reg[ib],
                                   state_reg[ic], state_reg[id]});
            rnd_next[ia] = q.a;
            rnd_next[ib] = q.b;
            rnd_next[ic] = q.c;
            rnd_next[id] = q.d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < STATE_WORDS; w++)
        begin
            if (cmd.load_init)
            begin
                state_reg[w] <= init_w[w];
            end
            else if (cmd.round_en)
            begin
                state_reg[w] <= rnd_next[w];
            end
            else if (cmd.final_add)
            begin
                state_reg[w] <= state_reg[w] + init_w[w];
            end
        end
    end

    // The block counter carries into nonce word 0 when it wraps.
    always_comb
    begin
        ctr_next    = ctr_reg;
        nonce0_next = nonce0_reg;
        if (cfg_we && cfg_index == CFG_BLOCK_COUNTER)
        begin
            ctr_next = lo_half;
        end
        else if (cfg_we && cfg_index == CFG_NONCE_0_TO_7)
        begin
            nonce0_next = lo_half;
        end
        else if (cmd.final_add)
        begin
            ctr_next = ctr_reg + 1'b1;
            if (&ctr_reg)
            begin
                nonce0_next = nonce0_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_WORDS; k++)
            begin
                key_reg[k] <= '0;
            end
            ctr_reg    <= '0;
            nonce0_reg <= '0;
            nonce1_reg <= '0;
            nonce2_reg <= '0;
        end
        else
        begin
            ctr_reg    <= ctr_next;
            nonce0_reg <= nonce0_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_0_TO_7:
                    begin
                        key_reg[0] <= lo_half;
                        key_reg[1] <= hi_half;
                    end
                    CFG_KEY_8_TO_15:
                    begin
                        key_reg[2] <= lo_half;
                        key_reg[3] <= hi_half;
                    end
                    CFG_KEY_16_TO_23:
                    begin
                        key_reg[4] <= lo_half;
                        key_reg[5] <= hi_half;
                    end
                    CFG_KEY_24_TO_31:
                    begin
                        key_reg[6] <= lo_half;
                        key_reg[7] <= hi_half;
                    end
                    CFG_NONCE_0_TO_7:
                    begin
                        nonce1_reg <= hi_half;
                    end
                    CFG_NONCE_8_TO_11:
                    begin
                        nonce2_reg <= lo_half;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Word position within the current block.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            if (end_of_message || pos_reg == POS_W'(STATE_WORDS - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign status.pos_zero = (pos_reg == '0);

    // Hold the first word of a block while its keystream is made.
    always_ff @(posedge clk)
    begin
        if (cmd.load_init)
        begin
            hold_word_reg  <= message_word;
            hold_count_reg <= byte_count;
            hold_last_reg  <= end_of_message;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_from_hold)
            begin
                cipher_word_reg <= hold_word_reg ^ state_reg[0];
                valid_bytes_reg <= hold_count_reg;
                final_word_reg  <= hold_last_reg;
            end
            else
            begin
                cipher_word_reg <= message_word ^ state_reg[pos_reg];
                valid_bytes_reg <= byte_count;
                final_word_reg  <= end_of_message;
            end
        end
    end

    assign cipher_word = cipher_word_reg;
    assign valid_bytes = valid_bytes_reg;
    assign final_word  = final_word_reg;

endmodule

FILE: src/cc20_ctrl.sv
// Controller: state machine that sequences block generation and the result register.
module cc20_ctrl
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUND_TOTAL = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  cc20_status_t status,
    output cc20_cmd_t    cmd
);

    localparam int ROUNDS    = (DOUBLE_ROUND_TOTAL / 2) * 2;
    localparam int RND_CNT_W = $clog2(ROUNDS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [RND_CNT_W-1:0] round_cnt_reg, round_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;
    logic                 in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        round_cnt_next = round_cnt_reg;
        cmd.accept     = in_fire;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (status.pos_zero)
                    begin
                        cmd.load_init  = 1'b1;
                        round_cnt_next = '0;
                        state_next     = S_ROUND;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.diag     = round_cnt_reg[0];
                if (round_cnt_reg == RND_CNT_W'(ROUNDS - 1))
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    round_cnt_next = round_cnt_reg + 1'b1;
                end
            end
            S_ADD:
            begin
                cmd.final_add = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_from_hold = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_start_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && status.pos_zero) |=> (state_reg == S_ROUND))
        else $error("first word of a block did not start the rounds");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> ({1'b0, round_cnt_reg} < (RND_CNT_W + 1)'(ROUNDS)))
        else $error("round counter ran past the round count");

    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && round_cnt_reg == RND_CNT_W'(ROUNDS - 1))
        |=> (state_reg == S_ADD))
        else $error("feed-forward add did not follow the last round");

endmodule

FILE: src/chacha20_stream_cipher.sv
// A block's first word waits while the block input is loaded, ROUNDS column or diagonal rounds run
// (ROUNDS = 20 by default, one round per cycle) and one feed-forward add is made; other words go
// straight to the result register. Words inside a block are taken one per cycle while the receiver
// takes results; no new word is taken while a block's rounds and add run.
// Reset: key, nonce and counter registers clear to zero, the word position returns to the block
// start and no beat is held; keystream words are undefined until the first block is made.
module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUND_TOTAL = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    cc20_msg_if.sink               message,
    cc20_res_if.source             cipher
);

    // The controller only sees handshakes and the block-start flag; it tells the
    // datapath when to load the block input, run a round, add back and load a result.
    cc20_cmd_t    cmd;
    cc20_status_t status;

    cc20_ctrl #(
        .DOUBLE_ROUND_TOTAL (DOUBLE_ROUND_TOTAL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (message.valid),
        .in_ready  (message.ready),
        .out_valid (cipher.valid),
        .out_ready (cipher.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath keeps the round state in sixteen registers; after the add-back
    // they hold the keystream block that later words of the block read from.
    cc20_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .message_word   (message.message_word),
        .byte_count     (message.byte_count),
        .end_of_message (message.end_of_message),
        .cmd            (cmd),
        .status         (status),
        .cipher_word    (cipher.cipher_word),
        .valid_bytes    (cipher.valid_bytes),
        .final_word     (cipher.final_word)
    );

endmodule

FILE: test/tb.sv
// Testbench for chacha20_stream_cipher: directed table plus random messages, checked beat by beat.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cc20_pkg::*;

    // The block is built with its default round count, so the predictor uses the same.
    localparam int ROUNDS        = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_BEATS = 88;
    localparam int PRESSURE_AT   = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 40;

    // Quarter-round lanes, one nibble per quarter: four column quarters, then four diagonals.
    localparam logic [31:0] LANE_A = 32'h3210_3210;
    localparam logic [31:0] LANE_B = 32'h4765_7654;
    localparam logic [31:0] LANE_C = 32'h98BA_BA98;
    localparam logic [31:0] LANE_D = 32'hEDCF_FEDC;

    // Keystream words 0 and 1 of the block made from an all-zero key, nonce and counter.
    localparam word_t ZERO_KEY_WORD_0 = 32'hADE0_B876;
    localparam word_t ZERO_KEY_WORD_1 = 32'h903D_F1A0;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One result beat as the block should return it.
    typedef struct packed {
        word_t              word;
        logic [COUNT_W-1:0] count;
        logic               last;
    } cipher_beat_t;

    // One row of the directed table: either a register write or a message beat.
    typedef struct {
        logic                   is_reg_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        word_t                  word;
        logic [COUNT_W-1:0]     count;
        logic                   last;
        logic                   pinned;
        word_t                  pinned_word;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cc20_msg_if message ();
    cc20_res_if cipher ();

    chacha20_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .message   (message),
        .cipher    (cipher)
    );

    // Predictor state: the configured key and nonce, the running counter and nonce word,
    // the keystream of the current block and the position of the next word in it.
    word_t            key_word [KEY_WORDS];
    word_t            nonce_low;
    word_t            nonce_mid;
    word_t            nonce_top;
    word_t            block_ctr;
    word_t            keystream [STATE_WORDS];
    logic [POS_W-1:0] word_pos;

    // Results that the block still owes, oldest first.
    cipher_beat_t cipher_due [$];
    stim_row_t    directed_rows [$];

    int mismatches   = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int tx_pct       = 0;
    int rx_pct       = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit offering     = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic word_t rol32(word_t v, int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic [4*WORD_W-1:0] quarter_mix(word_t a, word_t b, word_t c, word_t d);
        a = a + b; d = rol32(d ^ a, 16);
        c = c + d; b = rol32(b ^ c, 12);
        a = a + b; d = rol32(d ^ a, 8);
        c = c + d; b = rol32(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Makes the next 64-byte keystream block and advances the running counter; a counter
    // wrap carries into the running nonce word.
    function automatic void refill_keystream();
        word_t init [STATE_WORDS];
        word_t x [STATE_WORDS];
        int    la, lb, lc, ld;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            init[4 + i] = key_word[i];
        end
        init[12] = block_ctr;
        init[13] = nonce_low;
        init[14] = nonce_mid;
        init[15] = nonce_top;
        x = init;
        for (int r = 0; r < ROUNDS / 2; r++)
        begin
            for (int q = 0; q < 8; q++)
            begin
                la = LANE_A[4*q +: 4];
                lb = LANE_B[4*q +: 4];
                lc = LANE_C[4*q +: 4];
                ld = LANE_D[4*q +: 4];
                {x[la], x[lb], x[lc], x[ld]} = quarter_mix(x[la], x[lb], x[lc], x[ld]);
            end
        end
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            keystream[i] = x[i] + init[i];
        end
        block_ctr = block_ctr + 1;
        if (block_ctr == '0)
        begin
            nonce_low = nonce_low + 1;
        end
    endfunction

    function automatic cipher_beat_t predict_cipher(word_t w, logic [COUNT_W-1:0] cnt,
                                                    logic last);
        cipher_beat_t r;
        if (word_pos == '0)
        begin
            refill_keystream();
        end
        r.word  = w ^ keystream[word_pos];
        r.count = cnt;
        r.last  = last;
        // An end-of-message beat or the sixteenth word closes the block.
        if (last || word_pos == 4'd15)
        begin
            word_pos = '0;
        end
        else
        begin
            word_pos = word_pos + 1'b1;
        end
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_KEY_0_TO_7:    begin key_word[0] = v[31:0]; key_word[1] = v[63:32]; end
            CFG_KEY_8_TO_15:   begin key_word[2] = v[31:0]; key_word[3] = v[63:32]; end
            CFG_KEY_16_TO_23:  begin key_word[4] = v[31:0]; key_word[5] = v[63:32]; end
            CFG_KEY_24_TO_31:  begin key_word[6] = v[31:0]; key_word[7] = v[63:32]; end
            CFG_BLOCK_COUNTER: block_ctr = v[31:0];
            CFG_NONCE_0_TO_7:  begin nonce_low = v[31:0]; nonce_mid = v[63:32]; end
            CFG_NONCE_8_TO_11: nonce_top = v[31:0];
            default: ;
        endcase
    endfunction

    // Bytes past the byte count are don't-care; a count of zero or above four leaves all four bytes live.
    function automatic word_t live_byte_mask(logic [COUNT_W-1:0] cnt);
        case (cnt)
            3'd1:    return 32'h0000_00FF;
            3'd2:    return 32'h0000_FFFF;
            3'd3:    return 32'h00FF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Register values lean toward the extremes, and the counter often sits just below its
    // wrap so that the carry into the nonce word shows up within a segment.
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_INDEX_W-1:0] idx);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return '1;
        end
        else if (sel <= 4 && idx == CFG_BLOCK_COUNTER)
        begin
            return {32'($urandom), 32'hFFFF_FFFF - 32'($urandom_range(3))};
        end
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin tx_pct = 0;  rx_pct = 0;  end
            IDLE_SENDER:   begin tx_pct = 72; rx_pct = 0;  end
            IDLE_RECEIVER: begin tx_pct = 0;  rx_pct = 72; end
            default:       begin tx_pct = 25; rx_pct = 25; end
        endcase
    endtask

    task automatic add_beat(word_t w, logic [COUNT_W-1:0] cnt, logic last);
        directed_rows.push_back('{1'b0, '0, '0, w, cnt, last, 1'b0, '0});
    endtask

    task automatic add_pinned_beat(word_t w, logic [COUNT_W-1:0] cnt, logic last, word_t want);
        directed_rows.push_back('{1'b0, '0, '0, w, cnt, last, 1'b1, want});
    endtask

    task automatic add_reg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        directed_rows.push_back('{1'b1, idx, v, '0, '0, 1'b0, 1'b0, '0});
    endtask

    // Stops offering beats and waits until every owed result has come back.
    task automatic drain_block();
        if (offering)
        begin
            message.valid <= 1'b0;
            offering = 1'b0;
        end
        while (cipher_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes happen only with the block drained.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        apply_register(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one message beat, after a random gap, and books its result once accepted.
    // A valid that stays high between beats is never lowered and raised in one step.
    task automatic send_beat(word_t w, logic [COUNT_W-1:0] cnt, logic last,
                             logic pinned, word_t pinned_word);
        int           gap;
        cipher_beat_t due;
        gap = 0;
        while ($urandom_range(99) < tx_pct && gap < MAX_GAP)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            if (offering)
            begin
                message.valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        message.valid          <= 1'b1;
        message.message_word   <= w;
        message.byte_count     <= cnt;
        message.end_of_message <= last;
        offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!message.ready);
        due = predict_cipher(w, cnt, last);
        if (pinned)
        begin
            due.word = pinned_word;
        end
        cipher_due.push_back(due);
    endtask

    // Mostly well-formed messages of random length, with full words and a last word of one
    // to four bytes; the rest is noise with odd byte counts and stray end marks. A segment
    // may stop in the middle of a block, so the next register writes land mid-block.
    task automatic run_segment(int beats);
        int   sent;
        int   len;
        logic last;
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = ($urandom_range(3) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
                for (int k = 0; k < len && sent < beats; k++)
                begin
                    last = (k == len - 1);
                    send_beat($urandom, last ? 3'($urandom_range(1, 4)) : 3'd4, last, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len && sent < beats; k++)
                begin
                    send_beat($urandom, 3'($urandom_range(0, 7)), $urandom_range(3) == 0,
                              1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver side. Once, when enough results have come, it holds off for a long stretch
    // while the sender keeps offering, so the block fills up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            cipher.ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= PRESSURE_AT)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            cipher.ready <= 1'b0;
        end
        else
        begin
            cipher.ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    // Every accepted result beat is checked against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        cipher_beat_t due;
        word_t        mask;
        if (rst_n && cipher.valid && cipher.ready)
        begin
            results_seen <= results_seen + 1;
            if (cipher_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, got %h count %0d final %0b",
                         $time, cipher.cipher_word, cipher.valid_bytes, cipher.final_word);
            end
            else
            begin
                due  = cipher_due.pop_front();
                mask = live_byte_mask(due.count);
                if (((cipher.cipher_word ^ due.word) & mask) != '0 ||
                    cipher.valid_bytes != due.count || cipher.final_word != due.last)
                begin
                    mismatches++;
                    $display("%0t: mismatch, expected %h count %0d final %0b",
                             $time, due.word, due.count, due.last);
                    $display("%0t:           got      %h count %0d final %0b",
                             $time, cipher.cipher_word, cipher.valid_bytes, cipher.final_word);
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        message.valid          = 1'b0;
        message.message_word   = '0;
        message.byte_count     = '0;
        message.end_of_message = 1'b0;
        cipher.ready           = 1'b0;
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            key_word[i] = '0;
        end
        for (int i = 0; i < STATE_WORDS; i++)
        begin
            keystream[i] = '0;
        end
        nonce_low = '0;
        nonce_mid = '0;
        nonce_top = '0;
        block_ctr = '0;
        word_pos  = '0;
        set_idle_mode(IDLE_NONE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Right after reset the key, nonce and counter are zero, so the first
        // two words of an all-zero message are the well-known zero-key keystream.
        add_pinned_beat(32'h0000_0000, 3'd4, 1'b0, ZERO_KEY_WORD_0);
        add_pinned_beat(32'h0000_0000, 3'd4, 1'b0, ZERO_KEY_WORD_1);
        // Message extremes and every byte count, including the odd ones that are just
        // copied through; the end mark then cuts the block short.
        add_beat(32'hFFFF_FFFF, 3'd1, 1'b0);
        add_beat(32'h1234_5678, 3'd2, 1'b0);
        add_beat(32'hA5A5_A5A5, 3'd3, 1'b0);
        add_beat(32'h5A5A_5A5A, 3'd0, 1'b0);
        add_beat(32'h8000_0001, 3'd5, 1'b0);
        add_beat(32'h7FFF_FFFE, 3'd6, 1'b0);
        add_beat(32'hFFFF_FFFF, 3'd7, 1'b1);
        // All registers at their top values: the first block uses the last counter value,
        // then the counter wraps and carries into the running nonce word.
        add_reg_write(CFG_KEY_0_TO_7, '1);
        add_reg_write(CFG_KEY_8_TO_15, '1);
        add_reg_write(CFG_KEY_16_TO_23, '1);
        add_reg_write(CFG_KEY_24_TO_31, '1);
        add_reg_write(CFG_BLOCK_COUNTER, '1);
        add_reg_write(CFG_NONCE_0_TO_7, '1);
        add_reg_write(CFG_NONCE_8_TO_11, '1);
        // A full block of sixteen words runs into the next block without an end mark.
        for (int k = 0; k < 16; k++)
        begin
            add_beat(k[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0);
        end
        add_beat(32'hDEAD_BEEF, 3'd4, 1'b1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg_write)
            begin
                drain_block();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                send_beat(directed_rows[i].word, directed_rows[i].count, directed_rows[i].last,
                          directed_rows[i].pinned, directed_rows[i].pinned_word);
            end
        end

        // Random part: each segment rewrites some registers (all of them the first time)
        // and runs under its own idling pattern.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_block();
            for (int r = CFG_KEY_0_TO_7; r <= CFG_NONCE_8_TO_11; r++)
            begin
                if (seg == 0 || $urandom_range(1) == 1)
                begin
                    write_register(CFG_INDEX_W'(r), pick_reg_value(CFG_INDEX_W'(r)));
                end
            end
            set_idle_mode(idle_mode_t'(seg % 4));
            run_segment(SEGMENT_BEATS);
        end

        // Wait for the last owed results, then a little longer for any stray beat.
        drain_block();
        repeat (ROUNDS + 4) @(posedge clk);
        if (mismatches == 0 && cipher_due.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: chacha20_stream_cipher.f
src/cc20_pkg.sv
src/cc20_msg_if.sv
src/cc20_res_if.sv
src/cc20_datapath.sv
src/cc20_ctrl.sv
src/chacha20_stream_cipher.sv
test/tb.sv
